>>> hw/rtl/aba_pkg.sv
// aba_pkg: shared types, status codes, register indexes and helpers
// for the aligned bump allocator. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package aba_pkg;

    // overflow bound of the bump offset, 2^OFFSET_BITS - 1 (range 8..64)
    localparam int unsigned OFFSET_BITS = 32;
    localparam logic [64:0] OFFSET_LIMIT = (65'd1 << OFFSET_BITS) - 65'd1;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DISABLED     = 2'd2;

    // result status codes
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_ZERO_SIZE = 3'd1,
        ST_BAD_ALIGN = 3'd2,
        ST_DISABLED  = 3'd3,
        ST_OVERFLOW  = 3'd4,
        ST_NO_SPACE  = 3'd5
    } status_t;

    // region configuration as seen by the allocation core
    typedef struct packed {
        logic [31:0] base_address;
        logic [31:0] capacity;
        logic        disabled;
    } cfg_t;

    // one request beat
    typedef struct packed {
        logic [31:0] req_bytes;
        logic [31:0] align_bytes;
    } req_t;

    // one result beat
    typedef struct packed {
        status_t     status;
        logic [31:0] start_offset;
        logic [31:0] pad_bytes;
        logic [31:0] used_bytes;
        logic [31:0] peak_bytes;
        logic [31:0] grant_count;
        logic [31:0] refuse_count;
        logic [31:0] granted_total;
        logic [31:0] padding_total;
    } result_t;

    // 32-bit add that sticks at all ones
    function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/aba_cfg_regs.sv
// aba_cfg_regs: configuration register file of the aligned bump allocator
// Depends on aba_pkg for register indexes and the cfg_t type.
`timescale 1ns / 1ps
`default_nettype none

module aba_cfg_regs import aba_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]          cfg_data,
    output cfg_t                      cfg
);

    cfg_t cfg_reg;

    // writes are always taken; unknown indexes are dropped
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // register write beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_BASE_ADDRESS: cfg_reg.base_address <= cfg_data;
                CFG_CAPACITY:     cfg_reg.capacity     <= cfg_data;
                CFG_DISABLED:     cfg_reg.disabled     <= cfg_data[0];
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/aba_alloc_core.sv
// aba_alloc_core: allocation decision and running state (offset, peak, counters)
// Depends on aba_pkg for cfg_t, req_t, result_t, status codes and sat_add32.
`timescale 1ns / 1ps
`default_nettype none

module aba_alloc_core import aba_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire cfg_t cfg,
    input  wire req_t req,
    input  wire logic fire,
    output result_t   result
);

    logic [31:0] bump_reg,    bump_next;
    logic [31:0] peak_reg,    peak_next;
    logic [31:0] grants_reg,  grants_next;
    logic [31:0] refuse_reg,  refuse_next;
    logic [31:0] gsum_reg,    gsum_next;
    logic [31:0] psum_reg,    psum_next;

    logic [31:0] align_m1;
    logic        align_ok;
    logic [32:0] bump_end;
    logic        overflow;
    logic [32:0] abs_addr;
    logic [33:0] rounded;
    logic [33:0] aligned;
    logic [33:0] cand;
    logic [34:0] fit_end;
    logic        no_space;
    logic [31:0] pad;
    status_t     status;
    logic        grant;
    logic        refuse;

    // legality checks
    assign align_m1 = req.align_bytes - 32'd1;
    assign align_ok = (req.align_bytes != 32'd0) && ((req.align_bytes & align_m1) == 32'd0);
    assign bump_end = {1'b0, bump_reg} + {1'b0, req.req_bytes};
    assign overflow = {32'd0, bump_end} > OFFSET_LIMIT;

    // round the absolute address up, then back to an offset and test the fit
    assign abs_addr = {1'b0, cfg.base_address} + {1'b0, bump_reg};
    assign rounded  = {1'b0, abs_addr} + {2'b00, align_m1};
    assign aligned  = rounded & ~{2'b00, align_m1};
    assign cand     = aligned - {2'b00, cfg.base_address};
    assign fit_end  = {1'b0, cand} + {3'b000, req.req_bytes};
    assign no_space = fit_end > {3'b000, cfg.capacity};
    assign pad      = cand[31:0] - bump_reg;

    // first failing check decides the status
    always_comb begin
        if (req.req_bytes == 32'd0) begin
            status = ST_ZERO_SIZE;
        end else if (!align_ok) begin
            status = ST_BAD_ALIGN;
        end else if (cfg.disabled) begin
            status = ST_DISABLED;
        end else if (overflow) begin
            status = ST_OVERFLOW;
        end else if (no_space) begin
            status = ST_NO_SPACE;
        end else begin
            status = ST_OK;
        end
    end

    assign grant  = (status == ST_OK);
    assign refuse = (status == ST_OVERFLOW) || (status == ST_NO_SPACE);

    // next state after this request
    always_comb begin
        bump_next   = bump_reg;
        peak_next   = peak_reg;
        grants_next = grants_reg;
        refuse_next = refuse_reg;
        gsum_next   = gsum_reg;
        psum_next   = psum_reg;
        if (grant) begin
            bump_next   = fit_end[31:0];
            peak_next   = (fit_end[31:0] > peak_reg) ? fit_end[31:0] : peak_reg;
            grants_next = sat_add32(grants_reg, 32'd1);
            gsum_next   = sat_add32(gsum_reg, req.req_bytes);
            psum_next   = sat_add32(psum_reg, pad);
        end
        if (refuse) begin
            refuse_next = sat_add32(refuse_reg, 32'd1);
        end
    end

    // result seen with the state after this request
    always_comb begin
        result.status        = status;
        result.start_offset  = grant ? cand[31:0] : 32'd0;
        result.pad_bytes     = grant ? pad : 32'd0;
        result.used_bytes    = bump_next;
        result.peak_bytes    = peak_next;
        result.grant_count   = grants_next;
        result.refuse_count  = refuse_next;
        result.granted_total = gsum_next;
        result.padding_total = psum_next;
    end

    // running state, updated once per processed request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bump_reg   <= '0;
            peak_reg   <= '0;
            grants_reg <= '0;
            refuse_reg <= '0;
            gsum_reg   <= '0;
            psum_reg   <= '0;
        end else if (fire) begin
            bump_reg   <= bump_next;
            peak_reg   <= peak_next;
            grants_reg <= grants_next;
            refuse_reg <= refuse_next;
            gsum_reg   <= gsum_next;
            psum_reg   <= psum_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/aligned_bump_allocator.sv
// aligned_bump_allocator: top level, request register, core and result register
// Depends on aba_pkg, aba_cfg_regs and aba_alloc_core.
`timescale 1ns / 1ps
`default_nettype none

// Bump-pointer allocator over one region (base address, capacity, disable
// flag set through the cfg write port; the user must write it only while no
// request is in flight, which the block itself does not enforce). Each
// request beat carries a size and a power-of-two alignment and yields
// exactly one result beat: a status, the granted aligned start offset and
// padding, and the running offset, peak and saturating counters. Requests are
// taken one per clock unless the request side is stalled; a result passes the
// request register, then the result register, and the rate rests on the
// combinational round-up and fit check on the running bump offset.
// Back-pressure on the result side stalls the request side only when both registers are full.
module aligned_bump_allocator import aba_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // configuration write channel
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]          cfg_data,
    // request stream
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [63:0]          s_axis_tdata,   // req_bytes, align_bytes
    // result stream
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [263:0]              m_axis_tdata    // status, start_offset, pad_bytes,
                                                      // used_bytes, peak_bytes, grant_count,
                                                      // refuse_count, granted_total,
                                                      // padding_total, zero fill
);

    cfg_t    cfg;
    req_t    req_reg;
    logic    req_valid_reg;
    result_t core_result;
    result_t res_reg;
    logic    res_valid_reg;
    logic    advance;

    aba_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // move the held request into the result register when it has room
    assign advance       = req_valid_reg && (!res_valid_reg || m_axis_tready);
    assign s_axis_tready = !req_valid_reg || advance;

    // request register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            req_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            req_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            req_reg.req_bytes   <= s_axis_tdata[31:0];
            req_reg.align_bytes <= s_axis_tdata[63:32];
        end
    end

    aba_alloc_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .req     (req_reg),
        .fire    (advance),
        .result  (core_result)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_valid_reg <= 1'b0;
        end else if (advance) begin
            res_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= core_result;
        end
    end

    // pack result beat, first field lowest
    assign m_axis_tvalid = res_valid_reg;
    assign m_axis_tdata  = {5'd0,
                            res_reg.padding_total,
                            res_reg.granted_total,
                            res_reg.refuse_count,
                            res_reg.grant_count,
                            res_reg.peak_bytes,
                            res_reg.used_bytes,
                            res_reg.pad_bytes,
                            res_reg.start_offset,
                            res_reg.status};

endmodule

`default_nettype wire

>>> hw/rtl/aba_checker.sv
// aba_checker: port-level checks on the result stream of the allocator
// Bound to aligned_bump_allocator; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

module aba_checker (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         m_axis_tvalid,
    input wire logic         m_axis_tready,
    input wire logic [263:0] m_axis_tdata
);

    // no result beat right after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // stalled beat holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result beat changed");

    // refused request reports no block
    a_refuse_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (m_axis_tdata[2:0] != 3'd0) |-> (m_axis_tdata[66:3] == 64'd0))
        else $error("refused request carries offset or padding");

    // offset never exceeds the recorded peak
    a_used_le_peak: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tdata[98:67] <= m_axis_tdata[130:99]))
        else $error("used bytes above peak");

    // status code in range
    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tdata[2:0] <= 3'd5))
        else $error("status code out of range");

endmodule

bind aligned_bump_allocator aba_checker u_aba_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
